@@ hdl/teq_pkg.sv @@
// Shared constants, codes and control types for the timed event queue.
package teq_pkg;

   // Default sizes
   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int HANDLE_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT   = 48;
   localparam int COUNT_BITS_DEFAULT  = $clog2(QUEUE_DEPTH_DEFAULT + 1);

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd3;

   // Control broadcast to every cell
   typedef struct packed {
      logic capture;   // latch compare results against the incoming request
      logic apply;     // update the cell contents this cycle
      logic insert;    // update is an insert (else a shift toward slot 0)
   } teq_cmd_type;

endpackage

@@ hdl/teq_if.sv @@
// Request and response channel interfaces of the timed event queue.
interface teq_req_if #(
   parameter int HANDLE_BITS = teq_pkg::HANDLE_BITS_DEFAULT,
   parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [teq_pkg::OP_BITS-1:0]  operation;
   logic [HANDLE_BITS-1:0]       event_handle;
   logic [TIME_BITS-1:0]         event_time;

   modport source (output valid, output operation, output event_handle, output event_time,
                   input ready);
   modport sink   (input valid, input operation, input event_handle, input event_time,
                   output ready);
endinterface

interface teq_rsp_if #(
   parameter int HANDLE_BITS = teq_pkg::HANDLE_BITS_DEFAULT,
   parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS  = teq_pkg::COUNT_BITS_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic [teq_pkg::STATUS_BITS-1:0] status;
   logic [HANDLE_BITS-1:0]          out_handle;
   logic [TIME_BITS-1:0]            out_time;
   logic [COUNT_BITS-1:0]           entry_count;

   modport source (output valid, output status, output out_handle, output out_time,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input out_handle, input out_time,
                   input entry_count, output ready);
endinterface

@@ hdl/teq_cell.sv @@
// One queue slot: holds an entry, compares it with a request, shifts with its neighbors.
module teq_cell #(
   parameter int HANDLE_BITS = teq_pkg::HANDLE_BITS_DEFAULT,
   parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  teq_pkg::teq_cmd_type cmd,
   input  logic [HANDLE_BITS-1:0] key_handle,
   input  logic [TIME_BITS-1:0]   key_time,
   input  logic [HANDLE_BITS-1:0] new_handle,
   input  logic [TIME_BITS-1:0]   new_time,
   input  logic                   left_le,
   input  logic                   left_valid,
   input  logic [HANDLE_BITS-1:0] left_handle,
   input  logic [TIME_BITS-1:0]   left_time,
   input  logic                   right_valid,
   input  logic [HANDLE_BITS-1:0] right_handle,
   input  logic [TIME_BITS-1:0]   right_time,
   input  logic                   take_right,
   output logic                   slot_valid,
   output logic [HANDLE_BITS-1:0] slot_handle,
   output logic [TIME_BITS-1:0]   slot_time,
   output logic                   slot_le,
   output logic                   slot_match
);
   import teq_pkg::*;

   logic                   valid_ff, valid_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic                   le_ff, le_in;
   logic                   match_ff, match_in;

   // Compare against the request on its accept edge, hold otherwise
   always_comb begin
      le_in    = le_ff;
      match_in = match_ff;
      if (cmd.capture) begin
         le_in    = valid_ff && (time_ff <= key_time);
         match_in = valid_ff && (handle_ff == key_handle);
      end
   end

   // Hold, take the new entry, take the left neighbor, or take the right neighbor
   always_comb begin
      valid_in  = valid_ff;
      handle_in = handle_ff;
      time_in   = time_ff;
      if (cmd.apply) begin
         if (cmd.insert) begin
            if (!le_ff) begin
               if (left_le) begin
                  valid_in  = 1'b1;
                  handle_in = new_handle;
                  time_in   = new_time;
               end else begin
                  valid_in  = left_valid;
                  handle_in = left_handle;
                  time_in   = left_time;
               end
            end
         end else if (take_right) begin
            valid_in  = right_valid;
            handle_in = right_handle;
            time_in   = right_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         le_ff    <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         le_ff    <= le_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      time_ff   <= time_in;
   end

   assign slot_valid  = valid_ff;
   assign slot_handle = handle_ff;
   assign slot_time   = time_ff;
   assign slot_le     = le_ff;
   assign slot_match  = match_ff;

endmodule

@@ hdl/teq_scan.sv @@
// First-hit finder: log-step prefix OR over the cell match flags.
module teq_scan #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic [QUEUE_DEPTH-1:0] hit,
   output logic [QUEUE_DEPTH-1:0] incl,
   output logic [QUEUE_DEPTH-1:0] first,
   output logic                   any_hit
);
   import teq_pkg::*;

   logic [QUEUE_DEPTH-1:0] acc;

   // Mark every slot at or above the lowest hit
   always_comb begin
      acc = hit;
      for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
         acc = acc | (acc << s);
      end
   end

   assign incl    = acc;
   assign first   = hit & ~{acc[QUEUE_DEPTH-2:0], 1'b0};
   assign any_hit = acc[QUEUE_DEPTH-1];

endmodule

@@ hdl/timed_event_queue_core.sv @@
// Top level of the timed event queue: sorted row of slot cells with request control.
//
//  channel | dir | payload                                        | handshake
//  req     | in  | operation, event_handle, event_time            | valid / ready
//  rsp     | out | status, out_handle, out_time, entry_count      | valid / ready
//
// A request is handled as a compare step and then a shift step: on the accept edge
// every cell compares its entry with the request; then, in the execute state, the
// cells shift and the response register loads. A new request is taken once the
// shift is done; while a response waits unread, the shift holds until the response
// register frees. Synchronous reset clears all slot valid bits and the count.
module timed_event_queue_core #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int HANDLE_BITS = teq_pkg::HANDLE_BITS_DEFAULT,
   parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   teq_req_if.sink   req_port,
   teq_rsp_if.source rsp_port
);
   import teq_pkg::*;

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [OP_BITS-1:0]     op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [TIME_BITS-1:0]   time_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [TIME_BITS-1:0]   rsp_time_ff, rsp_time_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic req_accept;
   logic exec_fire;
   logic do_apply;
   teq_cmd_type cmd;

   logic                   cell_valid  [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]   cell_time   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_le;
   logic [QUEUE_DEPTH-1:0] cell_match;
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [QUEUE_DEPTH-1:0] match_incl;
   logic [QUEUE_DEPTH-1:0] match_first;
   logic                   match_any;
   logic [QUEUE_DEPTH-1:0] take_right;

   logic [HANDLE_BITS-1:0] sel_handle;
   logic [TIME_BITS-1:0]   sel_time;
   logic                   is_full;
   logic                   is_empty;

   // Handshake
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign exec_fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   assign is_full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // Latch the request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_port.operation;
         handle_ff <= req_port.event_handle;
         time_ff   <= req_port.event_time;
      end
   end

   // Decide whether the cells change and how
   always_comb begin
      do_apply   = 1'b0;
      take_right = '0;
      case (op_ff)
         OP_INSERT: do_apply = !is_full;
         OP_POP: begin
            do_apply   = !is_empty;
            take_right = '1;
         end
         OP_REMOVE: begin
            do_apply   = match_any;
            take_right = match_incl;
         end
         default: do_apply = 1'b0;
      endcase
   end

   assign cmd.capture = req_accept;
   assign cmd.apply   = exec_fire && do_apply;
   assign cmd.insert  = (op_ff == OP_INSERT);

   // Row of slot cells
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                   l_le;
      logic                   l_valid;
      logic [HANDLE_BITS-1:0] l_handle;
      logic [TIME_BITS-1:0]   l_time;
      logic                   r_valid;
      logic [HANDLE_BITS-1:0] r_handle;
      logic [TIME_BITS-1:0]   r_time;

      if (g == 0) begin : g_head
         assign l_le     = 1'b1;
         assign l_valid  = 1'b0;
         assign l_handle = '0;
         assign l_time   = '0;
      end else begin : g_left
         assign l_le     = cell_le[g-1];
         assign l_valid  = cell_valid[g-1];
         assign l_handle = cell_handle[g-1];
         assign l_time   = cell_time[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign r_valid  = 1'b0;
         assign r_handle = '0;
         assign r_time   = '0;
      end else begin : g_right
         assign r_valid  = cell_valid[g+1];
         assign r_handle = cell_handle[g+1];
         assign r_time   = cell_time[g+1];
      end

      teq_cell #(
         .HANDLE_BITS(HANDLE_BITS),
         .TIME_BITS  (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key_handle  (req_port.event_handle),
         .key_time    (req_port.event_time),
         .new_handle  (handle_ff),
         .new_time    (time_ff),
         .left_le     (l_le),
         .left_valid  (l_valid),
         .left_handle (l_handle),
         .left_time   (l_time),
         .right_valid (r_valid),
         .right_handle(r_handle),
         .right_time  (r_time),
         .take_right  (take_right[g]),
         .slot_valid  (cell_valid[g]),
         .slot_handle (cell_handle[g]),
         .slot_time   (cell_time[g]),
         .slot_le     (cell_le[g]),
         .slot_match  (cell_match[g])
      );

      assign valid_vec[g] = cell_valid[g];
   end

   teq_scan #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_scan (
      .hit    (cell_match),
      .incl   (match_incl),
      .first  (match_first),
      .any_hit(match_any)
   );

   // Pick the entry leaving the queue
   always_comb begin
      sel_handle = '0;
      sel_time   = '0;
      if (op_ff == OP_POP) begin
         sel_handle = cell_handle[0];
         sel_time   = cell_time[0];
      end else begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (match_first[i]) begin
               sel_handle = sel_handle | cell_handle[i];
               sel_time   = sel_time | cell_time[i];
            end
         end
      end
   end

   // Build the response and the new count
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_handle_in = '0;
      rsp_time_in   = '0;
      case (op_ff)
         OP_INSERT: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         OP_POP: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_handle_in = sel_handle;
               rsp_time_in   = sel_time;
               count_in      = count_ff - COUNT_BITS'(1);
            end
         end
         OP_REMOVE: begin
            if (!match_any) begin
               rsp_status_in = STATUS_NOT_FOUND;
            end else begin
               rsp_handle_in = sel_handle;
               rsp_time_in   = sel_time;
               count_in      = count_ff - COUNT_BITS'(1);
            end
         end
         default: count_in = count_ff;
      endcase
      rsp_count_in = count_in;
   end

   // Advance the sequencer and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: if (req_accept) begin
            state_in = ST_EXEC;
         end
         ST_EXEC: if (exec_fire) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.out_handle  = rsp_handle_ff;
   assign rsp_port.out_time    = rsp_time_ff;
   assign rsp_port.entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   // Count stays within the queue depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // Occupied slots agree with the count
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("slot valid bits disagree with count");

   // At most one slot is chosen for removal
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(match_first))
      else $error("more than one slot selected for removal");

   // A refused insert leaves the count unchanged
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && op_ff == OP_INSERT && is_full) |=> $stable(count_ff))
      else $error("count changed on refused insert");
`endif

endmodule

@@ sim/timed_event_queue_core_tb.sv @@
// Self-checking testbench for the timed event queue core: random operation traffic with prediction.
`timescale 1ns / 1ps

module timed_event_queue_core_tb;
   import teq_pkg::*;

   localparam int QD = QUEUE_DEPTH_DEFAULT;
   localparam int HB = HANDLE_BITS_DEFAULT;
   localparam int TB = TIME_BITS_DEFAULT;
   localparam int CB = COUNT_BITS_DEFAULT;

   // Code 3 is not a defined operation; the block treats it as a no-op
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_SPACING = 600;
   localparam int END_CYCLES   = 20;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [HB-1:0]      handle;
      logic [TB-1:0]      stamp;
      logic               drain_first;  // wait for all replies before offering
   } event_op_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [HB-1:0]          handle;
      logic [TB-1:0]          stamp;
      logic [CB-1:0]          count;
   } event_reply_type;

   logic clock;
   logic reset;

   teq_req_if #(.HANDLE_BITS(HB), .TIME_BITS(TB)) req_ch ();
   teq_rsp_if #(.HANDLE_BITS(HB), .TIME_BITS(TB), .COUNT_BITS(CB)) rsp_ch ();

   timed_event_queue_core #(
      .QUEUE_DEPTH (QD),
      .HANDLE_BITS (HB),
      .TIME_BITS   (TB)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   event_op_type    queued_ops[$];
   event_reply_type awaited_replies[$];
   logic [HB-1:0]   used_handles[$];

   // Shadow of the sorted slot row
   logic [TB-1:0] sched_time   [QD];
   logic [HB-1:0] sched_handle [QD];
   int unsigned   sched_count;

   int unsigned error_count;
   int unsigned replies_seen;
   int unsigned req_gap;
   int unsigned rsp_gap;
   int unsigned hold_left;
   int unsigned next_hold_at;
   int unsigned stall_cycles;
   logic        req_taken;
   logic        rsp_taken;
   logic        no_idle;

   // Close the slot at pos by shifting later entries toward slot 0
   function automatic void close_slot(input int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < sched_count; i++) begin
         sched_time[i]   = sched_time[i + 1];
         sched_handle[i] = sched_handle[i + 1];
      end
      sched_count--;
   endfunction

   // Apply one operation to the shadow row and return the reply it yields
   function automatic event_reply_type event_queue_apply(input logic [OP_BITS-1:0] op,
                                                         input logic [HB-1:0] h,
                                                         input logic [TB-1:0] t);
      event_reply_type r;
      int unsigned     pos;
      int unsigned     i;
      r = '0;
      r.status = STATUS_OK;
      case (op)
         OP_INSERT: begin
            if (sched_count >= QD) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < sched_count && sched_time[pos] <= t) pos++;
               for (i = sched_count; i > pos; i--) begin
                  sched_time[i]   = sched_time[i - 1];
                  sched_handle[i] = sched_handle[i - 1];
               end
               sched_time[pos]   = t;
               sched_handle[pos] = h;
               sched_count++;
            end
         end
         OP_POP: begin
            if (sched_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.handle = sched_handle[0];
               r.stamp  = sched_time[0];
               close_slot(0);
            end
         end
         OP_REMOVE: begin
            pos = 0;
            while (pos < sched_count && sched_handle[pos] != h) pos++;
            if (pos >= sched_count) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               r.handle = sched_handle[pos];
               r.stamp  = sched_time[pos];
               close_slot(pos);
            end
         end
         default: ;
      endcase
      r.count = sched_count[CB-1:0];
      return r;
   endfunction

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [HB-1:0] pick_handle();
      logic [HB-1:0] h;
      case ($urandom_range(0, 3))
         0, 1: h = HB'($urandom_range(0, 15));
         2: h = (used_handles.size() > 0) ?
                used_handles[$urandom_range(0, used_handles.size() - 1)] : HB'($urandom());
         default: h = HB'($urandom());
      endcase
      return h;
   endfunction

   function automatic logic [TB-1:0] pick_time();
      logic [63:0]   raw;
      logic [TB-1:0] t;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: t = raw[TB-1:0];
         5, 6, 7: t = TB'($urandom_range(0, 7));  // dense range to force ties
         8: t = '0;
         default: t = '1;
      endcase
      return t;
   endfunction

   task automatic push_op(input logic [OP_BITS-1:0] op, input logic [HB-1:0] h,
                          input logic [TB-1:0] t, input logic drain);
      event_op_type e;
      e.op          = op;
      e.handle      = h;
      e.stamp       = t;
      e.drain_first = drain;
      queued_ops.push_back(e);
      if (op == OP_INSERT) used_handles.push_back(h);
   endtask

   // Queue n random operations, inserts at roughly ins_pct percent
   task automatic push_mixed(input int n, input int ins_pct, input logic drain);
      int k;
      int r;
      logic [OP_BITS-1:0] op;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) op = OP_INSERT;
         else if (r >= 97) op = OP_UNUSED;
         else if (r[0]) op = OP_REMOVE;
         else op = OP_POP;
         push_op(op, pick_handle(), pick_time(), drain && (k == 0));
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Clock and reset
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      fork
         forever #1 clock = ~clock;
         begin
            repeat (10) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
         end
      join
   end

   // Stimulus and end of run
   initial begin
      int k;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_INSERT;
      req_ch.event_handle = '0;
      req_ch.event_time   = '0;
      rsp_ch.ready        = 1'b0;
      sched_count  = 0;
      error_count  = 0;
      replies_seen = 0;
      req_gap      = 0;
      rsp_gap      = 0;
      hold_left    = 0;
      next_hold_at = 300;
      stall_cycles = 0;
      req_taken    = 1'b0;
      rsp_taken    = 1'b0;
      no_idle      = 1'b0;

      // Empty queue cases and the unused code
      push_op(OP_POP,    '0,        '0, 1'b0);
      push_op(OP_REMOVE, 16'h1234,  '0, 1'b0);
      push_op(OP_UNUSED, '0,        '0, 1'b0);
      // Time extremes, ties kept in arrival order, duplicate handle
      push_op(OP_INSERT, '0,        '0, 1'b0);
      push_op(OP_INSERT, '1,        '1, 1'b0);
      push_op(OP_INSERT, 16'd1,     48'h1_0000, 1'b0);
      push_op(OP_INSERT, 16'd2,     48'h1_0000, 1'b0);
      push_op(OP_INSERT, 16'd3,     48'h1_0000, 1'b0);
      push_op(OP_INSERT, 16'd1,     48'd5, 1'b0);
      // Remove takes the first match in queue order
      push_op(OP_REMOVE, 16'd1,     '0, 1'b0);
      push_op(OP_REMOVE, 16'h7777,  '0, 1'b0);
      push_op(OP_UNUSED, 16'hBEEF,  48'hFFFF_0000_FFFF, 1'b0);
      push_op(OP_POP,    '0,        '0, 1'b0);
      push_op(OP_POP,    '1,        '1, 1'b0);
      push_op(OP_REMOVE, 16'hFFFF,  '0, 1'b0);
      push_op(OP_INSERT, 16'hAAAA,  48'hAAAA_AAAA_AAAA, 1'b0);
      push_op(OP_INSERT, 16'h5555,  48'h5555_5555_5555, 1'b0);
      push_op(OP_REMOVE, 16'd3,     '0, 1'b0);
      for (k = 0; k < 4; k++) push_op(OP_POP, '0, '0, 1'b0);

      // Random traffic around a shallow queue
      push_mixed(400, 45, 1'b1);
      // Fill past full, then churn near the top
      for (k = 0; k < QD + 4; k++) push_op(OP_INSERT, pick_handle(), pick_time(), k == 0);
      push_mixed(40, 70, 1'b0);
      // Deep queue traffic
      push_mixed(300, 55, 1'b0);
      // Drain past empty
      for (k = 0; k < QD + 6; k++) push_op(OP_POP, pick_handle(), pick_time(), k == 0);
      push_mixed(250, 45, 1'b1);

      while (queued_ops.size() != 0 || awaited_replies.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("timed_event_queue_core_tb OK");
      end else begin
         $display("timed_event_queue_core_tb NOT OK");
      end
      $finish;
   end

   // Record accepted requests and predict their replies
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            awaited_replies.push_back(event_queue_apply(req_ch.operation,
                                                        req_ch.event_handle,
                                                        req_ch.event_time));
            void'(queued_ops.pop_front());
         end
      end
   end

   // Drive requests: hold until accepted, then idle for the drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the offered request
      end else if (req_gap > 0) begin
         req_ch.valid <= 1'b0;
         req_gap--;
      end else if (queued_ops.size() == 0 ||
                   (queued_ops[0].drain_first && awaited_replies.size() != 0)) begin
         req_ch.valid <= 1'b0;
      end else begin
         req_ch.valid        <= 1'b1;
         req_ch.operation    <= queued_ops[0].op;
         req_ch.event_handle <= queued_ops[0].handle;
         req_ch.event_time   <= queued_ops[0].stamp;
         req_gap = draw_gap();
      end
   end

   // Check each reply against the oldest prediction
   always @(posedge clock) begin
      event_reply_type want;
      if (reset) begin
         rsp_taken <= 1'b0;
      end else begin
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none, actual status %0h handle %0h",
                        $time, rsp_ch.status, rsp_ch.out_handle);
               error_count++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("status",      64'(want.status), 64'(rsp_ch.status));
               check_field("out_handle",  64'(want.handle), 64'(rsp_ch.out_handle));
               check_field("out_time",    64'(want.stamp),  64'(rsp_ch.out_time));
               check_field("entry_count", 64'(want.count),  64'(rsp_ch.entry_count));
            end
         end
      end
   end

   // Drive ready: per-reply gaps, a long hold now and then, a calm stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         no_idle <= (replies_seen >= 500 && replies_seen < 650);
         if (replies_seen >= next_hold_at) begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (rsp_taken) begin
            rsp_gap = draw_gap();
            if (rsp_gap == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               rsp_gap--;
            end
         end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
         $display("timed_event_queue_core_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

@@ sim.f @@
hdl/teq_pkg.sv
hdl/teq_if.sv
hdl/teq_cell.sv
hdl/teq_scan.sv
hdl/timed_event_queue_core.sv
sim/timed_event_queue_core_tb.sv
